/* hdl/mtep_pkg.sv */
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and codes for the MIDI track event parser: parse phases,
// event kinds, the parser state word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

  // Longest variable-length quantity, in bytes (delta time or payload length)
  localparam int unsigned MAX_VLQ_BYTES = 4;
  localparam logic [2:0]  VLQ_LIMIT     = 3'(MAX_VLQ_BYTES);

  // Parse phases
  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_DATA1     = 4'd2;
  localparam logic [3:0] PH_DATA2     = 4'd3;
  localparam logic [3:0] PH_META_TYPE = 4'd4;
  localparam logic [3:0] PH_META_LEN  = 4'd5;
  localparam logic [3:0] PH_META_DATA = 4'd6;
  localparam logic [3:0] PH_SYX_LEN   = 4'd7;
  localparam logic [3:0] PH_SYX_DATA  = 4'd8;
  localparam logic [3:0] PH_DISCARD   = 4'd9;

  // Event kinds
  localparam logic [3:0] KIND_TEMPO     = 4'd7;
  localparam logic [3:0] KIND_TIMESIG   = 4'd8;
  localparam logic [3:0] KIND_END       = 4'd9;
  localparam logic [3:0] KIND_META      = 4'd10;
  localparam logic [3:0] KIND_SYSEX     = 4'd11;
  localparam logic [3:0] KIND_MALFORMED = 4'd12;

  // Status and meta codes
  localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
  localparam logic [7:0] STATUS_META    = 8'hFF;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_END       = 8'h2F;
  localparam logic [7:0] META_TIMESIG   = 8'h58;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  running_status;
    logic [27:0] delta_accum;
    logic [2:0]  byte_count;
    logic [31:0] tick_total;
    logic [7:0]  held_first;
    logic [7:0]  held_second;
    logic [7:0]  meta_code;
    logic [27:0] payload_left;
    logic [23:0] tempo_accum;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_DELTA,
    running_status: 8'd0,
    delta_accum:    28'd0,
    byte_count:     3'd0,
    tick_total:     32'd0,
    held_first:     8'd0,
    held_second:    8'd0,
    meta_code:      8'd0,
    payload_left:   28'd0,
    tempo_accum:    24'd0
  };

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [3:0]  channel_number;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [27:0] delta_ticks;
    logic [31:0] total_ticks;
    logic [23:0] tempo_us;
    logic        format_error;
  } result_t;

endpackage

`default_nettype wire

/* hdl/mtep_step.sv */
// ----------------------------------------------------------------------------
// mtep_step
// Next-state and result logic for one byte of the track chunk body.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_step import mtep_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output state_t     state_o,
  output logic       emit_o,
  output result_t    result_o
);

  state_t      nx;
  result_t     res;
  logic        emit;
  logic        put_meta;
  logic        put_chan;
  logic [2:0]  cnt_inc;
  logic [27:0] acc_base;
  logic [27:0] len_next;

  always_comb begin
    nx       = state_i;
    res      = '0;
    emit     = 1'b0;
    put_meta = 1'b0;
    put_chan = 1'b0;
    cnt_inc  = 3'(state_i.byte_count + 3'd1);
    acc_base = (state_i.byte_count == 3'd0) ? 28'd0 : state_i.delta_accum;
    len_next = {state_i.payload_left[20:0], data_byte_i[6:0]};

    case (state_i.phase)
      // variable-length delta time
      PH_DELTA: begin
        nx.delta_accum = {acc_base[20:0], data_byte_i[6:0]};
        nx.byte_count  = cnt_inc;
        if (!data_byte_i[7]) begin
          nx.tick_total = state_i.tick_total + 32'(nx.delta_accum);
          nx.byte_count = 3'd0;
          nx.phase      = PH_STATUS;
        end else if (cnt_inc >= VLQ_LIMIT) begin
          emit                 = 1'b1;
          res.event_kind       = KIND_MALFORMED;
          res.format_error     = 1'b1;
          nx.byte_count        = 3'd0;
          nx.phase             = PH_DISCARD;
        end
      end
      // status byte, or first data byte under running status
      PH_STATUS: begin
        if (!data_byte_i[7]) begin
          if (state_i.running_status == 8'd0) begin
            emit           = 1'b1;
            res.event_kind = KIND_MALFORMED;
            nx.phase       = PH_DELTA;
          end else begin
            nx.held_first = {1'b0, data_byte_i[6:0]};
            if (state_i.running_status[7:5] == 3'b110) begin
              put_chan = 1'b1;
              nx.phase = PH_DELTA;
            end else begin
              nx.phase = PH_DATA2;
            end
          end
        end else if (data_byte_i < STATUS_SYSEX) begin
          nx.running_status = data_byte_i;
          nx.phase          = PH_DATA1;
        end else if (data_byte_i == STATUS_META) begin
          nx.running_status = 8'd0;
          nx.phase          = PH_META_TYPE;
        end else if (data_byte_i == STATUS_SYSEX || data_byte_i == STATUS_ESCAPE) begin
          nx.running_status = 8'd0;
          nx.payload_left   = 28'd0;
          nx.byte_count     = 3'd0;
          nx.phase          = PH_SYX_LEN;
        end else begin
          emit           = 1'b1;
          res.event_kind = KIND_MALFORMED;
          nx.phase       = PH_DELTA;
        end
      end
      PH_DATA1: begin
        nx.held_first = {1'b0, data_byte_i[6:0]};
        if (state_i.running_status[7:5] == 3'b110) begin
          put_chan = 1'b1;
          nx.phase = PH_DELTA;
        end else begin
          nx.phase = PH_DATA2;
        end
      end
      PH_DATA2: begin
        put_chan        = 1'b1;
        res.second_data = {1'b0, data_byte_i[6:0]};
        nx.phase        = PH_DELTA;
      end
      PH_META_TYPE: begin
        nx.meta_code    = data_byte_i;
        nx.payload_left = 28'd0;
        nx.byte_count   = 3'd0;
        nx.phase        = PH_META_LEN;
      end
      // payload length of a meta or sysex event
      PH_META_LEN, PH_SYX_LEN: begin
        nx.payload_left = len_next;
        nx.byte_count   = cnt_inc;
        if (!data_byte_i[7]) begin
          nx.byte_count  = 3'd0;
          nx.held_first  = 8'd0;
          nx.held_second = 8'd0;
          nx.tempo_accum = 24'd0;
          if (len_next == 28'd0) begin
            if (state_i.phase == PH_META_LEN) begin
              put_meta = 1'b1;
            end else begin
              emit           = 1'b1;
              res.event_kind = KIND_SYSEX;
            end
            nx.phase = PH_DELTA;
          end else begin
            nx.phase = (state_i.phase == PH_META_LEN) ? PH_META_DATA : PH_SYX_DATA;
          end
        end else if (cnt_inc >= VLQ_LIMIT) begin
          emit             = 1'b1;
          res.event_kind   = KIND_MALFORMED;
          res.format_error = 1'b1;
          nx.byte_count    = 3'd0;
          nx.phase         = PH_DISCARD;
        end
      end
      // meta payload: keep the first bytes, skip the rest
      PH_META_DATA: begin
        if (state_i.byte_count == 3'd0) begin
          nx.held_first = data_byte_i;
        end else if (state_i.byte_count == 3'd1) begin
          nx.held_second = data_byte_i;
        end
        if (state_i.byte_count < 3'd3) begin
          nx.tempo_accum = {state_i.tempo_accum[15:0], data_byte_i};
          nx.byte_count  = cnt_inc;
        end
        nx.payload_left = state_i.payload_left - 28'd1;
        if (nx.payload_left == 28'd0) begin
          put_meta      = 1'b1;
          nx.byte_count = 3'd0;
          nx.phase      = PH_DELTA;
        end
      end
      PH_SYX_DATA: begin
        nx.payload_left = state_i.payload_left - 28'd1;
        if (nx.payload_left == 28'd0) begin
          emit           = 1'b1;
          res.event_kind = KIND_SYSEX;
          nx.phase       = PH_DELTA;
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        nx.phase = PH_DELTA;
      end
    endcase

    // channel message result
    if (put_chan) begin
      emit               = 1'b1;
      res.event_kind     = 4'(nx.running_status[7:4] - 4'd8);
      res.channel_number = nx.running_status[3:0];
      res.first_data     = nx.held_first;
    end

    // meta event result
    if (put_meta) begin
      emit = 1'b1;
      if (nx.meta_code == META_TEMPO) begin
        res.event_kind = KIND_TEMPO;
        res.tempo_us   = nx.tempo_accum;
      end else if (nx.meta_code == META_TIMESIG) begin
        res.event_kind  = KIND_TIMESIG;
        res.first_data  = nx.held_first;
        res.second_data = nx.held_second;
      end else if (nx.meta_code == META_END) begin
        res.event_kind = KIND_END;
      end else begin
        res.event_kind = KIND_META;
      end
    end

    // chunk end: flag an event left unfinished, then back to idle
    if (last_byte_i) begin
      if (!emit && nx.phase != PH_DISCARD &&
          (nx.phase != PH_DELTA || nx.byte_count != 3'd0)) begin
        emit             = 1'b1;
        res              = '0;
        res.event_kind   = KIND_MALFORMED;
        res.format_error = 1'b1;
      end
    end

    res.delta_ticks = nx.delta_accum;
    res.total_ticks = nx.tick_total;

    if (last_byte_i) begin
      nx = STATE_RESET;
    end
  end

  assign state_o  = nx;
  assign emit_o   = emit;
  assign result_o = res;

endmodule

`default_nettype wire

/* hdl/mtep_out_stage.sv */
// ----------------------------------------------------------------------------
// mtep_out_stage
// Result register: holds one event word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_out_stage import mtep_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    emit_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  // valid: new word on load, cleared once taken
  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = emit_i;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

/* hdl/midi_track_event_parser.sv */
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Byte-serial parser for the body of one standard MIDI file track chunk.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one chunk byte per word with
//   last_byte_i marking the final byte of the chunk. Output channel
//   (out_valid_o/out_ready_i) gives one word per finished event, malformed
//   events included; many bytes give no word at all.
//   An accepted byte is held in the input register; its event word is
//   loaded into the result register as the byte moves on, and offered there.
//   Throughput is one byte per cycle while the receiver keeps up; the parse
//   state update is a single pass of logic between the input and result
//   registers.
//   If the result register holds a word that is not taken, the input register
//   holds its byte and in_ready_o drops until the result moves on.
//   Reset empties both registers and returns the parser to awaiting a delta
//   time with no running status and a zero tick total; the byte marked last
//   does the same to the parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_event_parser import mtep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_kind_o,
  output logic [3:0]  channel_number_o,
  output logic [7:0]  first_data_o,
  output logic [7:0]  second_data_o,
  output logic [27:0] delta_ticks_o,
  output logic [31:0] total_ticks_o,
  output logic [23:0] tempo_us_o,
  output logic        format_error_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       adv;
  state_t     state_q, state_d;
  logic       emit;
  result_t    step_res;
  result_t    out_res;

  // byte moves on when the result register is free or being emptied
  assign adv        = in_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  mtep_step u_step (
    .state_i     (state_q),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .result_o    (step_res)
  );

  mtep_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .emit_i      (emit),
    .result_i    (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign event_kind_o     = out_res.event_kind;
  assign channel_number_o = out_res.channel_number;
  assign first_data_o     = out_res.first_data;
  assign second_data_o    = out_res.second_data;
  assign delta_ticks_o    = out_res.delta_ticks;
  assign total_ticks_o    = out_res.total_ticks;
  assign tempo_us_o       = out_res.tempo_us;
  assign format_error_o   = out_res.format_error;

  // a processed last byte leaves the parser idle
  a_chunk_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_q |=> state_q.phase == PH_DELTA && state_q.tick_total == 32'd0 &&
                      state_q.running_status == 8'd0 && state_q.byte_count == 3'd0)
    else $error("parser not idle after chunk end");

  // a flagged format error only comes with a malformed event
  a_error_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && format_error_o |-> event_kind_o == KIND_MALFORMED)
    else $error("format error on a well-formed event");

  // a stalled byte in the input register is not lost
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(byte_q) && $stable(last_q))
    else $error("stalled input byte dropped");

  // the byte count stays cleared while the rest of the chunk is discarded
  a_discard_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_DISCARD |-> state_q.byte_count == 3'd0)
    else $error("byte count not cleared in discard");

endmodule

`default_nettype wire

/* verif/tb_midi_track_event_parser.sv */
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser
// Self-checking bench for the byte-serial MIDI track event parser. Track chunk
// bodies are fed one byte per word. A software copy of the parser predicts
// each event word, and every word taken from the output channel is checked
// field by field against the oldest prediction. Directed chunks come first.
// Random chunks follow: channel messages with and without running status,
// meta and sysex events, undefined statuses, overlong delta and length
// encodings, and chunks cut short. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import mtep_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_BYTES = 1350;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Status and meta codes used to build stimulus
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_PROGRAM   = 8'hC5;
  localparam logic [7:0] ST_UNDEFINED = 8'hF9;
  localparam logic [7:0] META_TEXT    = 8'h01;
  // Top three status bits of program change and channel pressure (one data byte)
  localparam logic [2:0] ONE_DATA_GROUP = 3'b110;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  event_kind_o;
  logic [3:0]  channel_number_o;
  logic [7:0]  first_data_o;
  logic [7:0]  second_data_o;
  logic [27:0] delta_ticks_o;
  logic [31:0] total_ticks_o;
  logic [23:0] tempo_us_o;
  logic        format_error_o;

  midi_track_event_parser u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .channel_number_o (channel_number_o),
    .first_data_o     (first_data_o),
    .second_data_o    (second_data_o),
    .delta_ticks_o    (delta_ticks_o),
    .total_ticks_o    (total_ticks_o),
    .tempo_us_o       (tempo_us_o),
    .format_error_o   (format_error_o)
  );

  // Predicted parser state
  logic [3:0]  ps_phase;
  logic [7:0]  ps_status;
  logic [27:0] ps_delta;
  logic [2:0]  ps_count;
  logic [31:0] ps_ticks;
  logic [7:0]  ps_first;
  logic [7:0]  ps_second;
  logic [7:0]  ps_meta;
  logic [27:0] ps_left;
  logic [23:0] ps_tempo;

  result_t     pending_events[$];
  result_t     oldest_event;
  logic [7:0]  chunk_bytes[$];
  logic [15:0] kinds_seen;
  int unsigned bytes_sent;
  int unsigned chunks_sent;
  int unsigned events_checked;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          steady_mode;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run guard
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still expected", cycle_count,
               pending_events.size());
      $display("[midi_track_event_parser] ERROR");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: ready in runs, with random stalls unless the stream is steady
  initial begin
    int unsigned hold;
    out_ready_i = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (steady_mode || $urandom_range(0, 3) != 0) begin
        out_ready_i = 1'b1;
        hold = $urandom_range(0, 8);
      end else begin
        out_ready_i = 1'b0;
        hold = pick_gap();
      end
    end
  end

  // ------------------------------------------------------------------
  // Parser prediction
  // ------------------------------------------------------------------
  task automatic clear_track_state();
    ps_phase  = PH_DELTA;
    ps_status = '0;
    ps_delta  = '0;
    ps_count  = '0;
    ps_ticks  = '0;
    ps_first  = '0;
    ps_second = '0;
    ps_meta   = '0;
    ps_left   = '0;
    ps_tempo  = '0;
  endtask

  // Event word as it leaves the parser now: current delta and tick total
  function automatic result_t make_event(input logic [3:0] kind, input logic [3:0] chan,
                                         input logic [7:0] a, input logic [7:0] bb,
                                         input logic [23:0] tempo, input logic err);
    result_t r;
    r.event_kind     = kind;
    r.channel_number = chan;
    r.first_data     = a;
    r.second_data    = bb;
    r.delta_ticks    = ps_delta;
    r.total_ticks    = ps_ticks;
    r.tempo_us       = tempo;
    r.format_error   = err;
    return r;
  endfunction

  function automatic result_t malformed_event(input logic err);
    return make_event(KIND_MALFORMED, 4'd0, 8'd0, 8'd0, 24'd0, err);
  endfunction

  // Channel kinds follow the status high nibble: 8 -> note off ... E -> bend
  function automatic result_t channel_event(input logic [7:0] a, input logic [7:0] bb);
    return make_event(ps_status[7:4] - 4'd8, ps_status[3:0], a, bb, 24'd0, 1'b0);
  endfunction

  function automatic result_t meta_event();
    case (ps_meta)
      META_TEMPO:   return make_event(KIND_TEMPO, 4'd0, 8'd0, 8'd0, ps_tempo, 1'b0);
      META_TIMESIG: return make_event(KIND_TIMESIG, 4'd0, ps_first, ps_second, 24'd0, 1'b0);
      META_END:     return make_event(KIND_END, 4'd0, 8'd0, 8'd0, 24'd0, 1'b0);
      default:      return make_event(KIND_META, 4'd0, 8'd0, 8'd0, 24'd0, 1'b0);
    endcase
  endfunction

  // First data byte; program and channel pressure finish here
  task automatic take_data1(input logic [7:0] b, output bit hit, output result_t ev);
    hit = 1'b0;
    ev  = '0;
    ps_first = {1'b0, b[6:0]};
    if (ps_status[7:5] == ONE_DATA_GROUP) begin
      ev = channel_event(ps_first, 8'd0);
      hit = 1'b1;
      ps_phase = PH_DELTA;
    end else begin
      ps_phase = PH_DATA2;
    end
  endtask

  // One byte of a meta or sysex payload length
  task automatic take_length(input logic [7:0] b, input bit is_meta, output bit hit,
                             output result_t ev);
    hit = 1'b0;
    ev  = '0;
    ps_left = {ps_left[20:0], b[6:0]};
    ps_count++;
    if (!b[7]) begin
      ps_count  = '0;
      ps_first  = '0;
      ps_second = '0;
      ps_tempo  = '0;
      if (ps_left == '0) begin
        ev = is_meta ? meta_event() : make_event(KIND_SYSEX, 4'd0, 8'd0, 8'd0, 24'd0, 1'b0);
        hit = 1'b1;
        ps_phase = PH_DELTA;
      end else begin
        ps_phase = is_meta ? PH_META_DATA : PH_SYX_DATA;
      end
    end else if (ps_count >= VLQ_LIMIT) begin
      ev = malformed_event(1'b1);
      hit = 1'b1;
      ps_count = '0;
      ps_phase = PH_DISCARD;
    end
  endtask

  // Advance the predicted parser by one byte
  task automatic parse_track_byte(input logic [7:0] b, input logic is_last, output bit hit,
                                  output result_t ev);
    hit = 1'b0;
    ev  = '0;
    case (ps_phase)
      PH_DELTA: begin
        if (ps_count == '0) ps_delta = '0;
        ps_delta = {ps_delta[20:0], b[6:0]};
        ps_count++;
        if (!b[7]) begin
          ps_ticks = ps_ticks + 32'(ps_delta);
          ps_count = '0;
          ps_phase = PH_STATUS;
        end else if (ps_count >= VLQ_LIMIT) begin
          ev = malformed_event(1'b1);
          hit = 1'b1;
          ps_count = '0;
          ps_phase = PH_DISCARD;
        end
      end
      PH_STATUS: begin
        if (!b[7]) begin
          // data in place of a status: running status or nothing to run on
          if (ps_status == '0) begin
            ev = malformed_event(1'b0);
            hit = 1'b1;
            ps_phase = PH_DELTA;
          end else begin
            take_data1(b, hit, ev);
          end
        end else if (b < STATUS_SYSEX) begin
          ps_status = b;
          ps_phase = PH_DATA1;
        end else if (b == STATUS_META) begin
          ps_status = '0;
          ps_phase = PH_META_TYPE;
        end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
          ps_status = '0;
          ps_left = '0;
          ps_count = '0;
          ps_phase = PH_SYX_LEN;
        end else begin
          // system common / realtime status: flagged, running status kept
          ev = malformed_event(1'b0);
          hit = 1'b1;
          ps_phase = PH_DELTA;
        end
      end
      PH_DATA1: take_data1(b, hit, ev);
      PH_DATA2: begin
        ev = channel_event(ps_first, {1'b0, b[6:0]});
        hit = 1'b1;
        ps_phase = PH_DELTA;
      end
      PH_META_TYPE: begin
        ps_meta = b;
        ps_left = '0;
        ps_count = '0;
        ps_phase = PH_META_LEN;
      end
      PH_META_LEN: take_length(b, 1'b1, hit, ev);
      PH_SYX_LEN:  take_length(b, 1'b0, hit, ev);
      PH_META_DATA: begin
        // first two bytes held for time signature, first three form the tempo
        if (ps_count == 3'd0) ps_first = b;
        else if (ps_count == 3'd1) ps_second = b;
        if (ps_count < 3'd3) begin
          ps_tempo = {ps_tempo[15:0], b};
          ps_count++;
        end
        ps_left = ps_left - 28'd1;
        if (ps_left == '0) begin
          ev = meta_event();
          hit = 1'b1;
          ps_count = '0;
          ps_phase = PH_DELTA;
        end
      end
      PH_SYX_DATA: begin
        ps_left = ps_left - 28'd1;
        if (ps_left == '0) begin
          ev = make_event(KIND_SYSEX, 4'd0, 8'd0, 8'd0, 24'd0, 1'b0);
          hit = 1'b1;
          ps_phase = PH_DELTA;
        end
      end
      PH_DISCARD: ;
      default: ps_phase = PH_DELTA;
    endcase
    // chunk end: an event still open is cut
    if (is_last) begin
      if (!hit && ps_phase != PH_DISCARD && (ps_phase != PH_DELTA || ps_count != '0)) begin
        ev = malformed_event(1'b1);
        hit = 1'b1;
      end
      clear_track_state();
    end
  endtask

  // ------------------------------------------------------------------
  // Byte sender
  // ------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    bit          hit;
    result_t     ev;
    gap = steady_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = b;
    last_byte_i = is_last;
    do @(posedge clk_i); while (!in_ready_o);
    parse_track_byte(b, is_last, hit, ev);
    if (hit) pending_events = {pending_events, ev};
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_chunk();
    for (int i = 0; i < chunk_bytes.size(); i++) begin
      send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
    end
    chunk_bytes.delete();
    chunks_sent++;
  endtask

  // ------------------------------------------------------------------
  // Output checker
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      kinds_seen[event_kind_o] = 1'b1;
      if (pending_events.size() == 0) begin
        $error("event word with none expected: kind %0d, delta %0d", event_kind_o,
               delta_ticks_o);
        fail_count++;
      end else begin
        oldest_event = pending_events.pop_front();
        events_checked++;
        if (event_kind_o !== oldest_event.event_kind) begin
          $error("event_kind: expected %0d, got %0d", oldest_event.event_kind, event_kind_o);
          fail_count++;
        end
        if (channel_number_o !== oldest_event.channel_number) begin
          $error("channel_number: expected %0d, got %0d", oldest_event.channel_number,
                 channel_number_o);
          fail_count++;
        end
        if (first_data_o !== oldest_event.first_data) begin
          $error("first_data: expected %0h, got %0h", oldest_event.first_data, first_data_o);
          fail_count++;
        end
        if (second_data_o !== oldest_event.second_data) begin
          $error("second_data: expected %0h, got %0h", oldest_event.second_data,
                 second_data_o);
          fail_count++;
        end
        if (delta_ticks_o !== oldest_event.delta_ticks) begin
          $error("delta_ticks: expected %0d, got %0d", oldest_event.delta_ticks,
                 delta_ticks_o);
          fail_count++;
        end
        if (total_ticks_o !== oldest_event.total_ticks) begin
          $error("total_ticks: expected %0d, got %0d", oldest_event.total_ticks,
                 total_ticks_o);
          fail_count++;
        end
        if (tempo_us_o !== oldest_event.tempo_us) begin
          $error("tempo_us: expected %0d, got %0d", oldest_event.tempo_us, tempo_us_o);
          fail_count++;
        end
        if (format_error_o !== oldest_event.format_error) begin
          $error("format_error: expected %0b, got %0b", oldest_event.format_error,
                 format_error_o);
          fail_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Random chunk building
  // ------------------------------------------------------------------
  // Append one byte to the chunk being built
  task automatic add_chunk_byte(input logic [7:0] b);
    chunk_bytes = {chunk_bytes, b};
  endtask

  // Variable-length quantity, shortest form
  task automatic push_vlq(input logic [27:0] v);
    int n;
    n = 1;
    for (int i = 1; i < 4; i++) begin
      if ((v >> (7 * i)) != 0) n = i + 1;
    end
    for (int i = n - 1; i >= 0; i--) begin
      add_chunk_byte({i != 0, v[7 * i +: 7]});
    end
  endtask

  task automatic push_delta(input bit slow_track);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (slow_track) push_vlq(28'hFFFFFFF - 28'($urandom_range(0, 255)));
    else if (r < 45) push_vlq(28'd0);
    else if (r < 75) push_vlq(28'($urandom_range(1, 127)));
    else if (r < 88) push_vlq(28'($urandom_range(128, 16383)));
    else if (r < 94) push_vlq(28'($urandom_range(16384, 28'hFFFFFFF)));
    else if (r < 97) push_vlq(28'hFFFFFFF);
    else begin
      // padded encoding with a leading zero group
      add_chunk_byte(8'h80);
      add_chunk_byte(8'($urandom_range(0, 127)));
    end
  endtask

  // Data bytes are mostly clean, sometimes with the top bit set
  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic push_channel_data(input logic [7:0] status);
    add_chunk_byte(rand_data());
    if (status[7:5] != ONE_DATA_GROUP) add_chunk_byte(rand_data());
  endtask

  task automatic push_payload(input int unsigned len);
    repeat (len) add_chunk_byte(8'($urandom_range(0, 255)));
  endtask

  // One event; returns 1 when an overlong encoding sent the parser to discard
  task automatic push_event(inout logic [7:0] gen_status, input bit slow_track,
                            output bit discarding);
    int unsigned r;
    int unsigned len;
    logic [7:0]  code;
    discarding = 1'b0;
    r = $urandom_range(0, 99);
    if (r >= 98) begin
      repeat (4) add_chunk_byte(8'($urandom_range(128, 255)));
      discarding = 1'b1;
      return;
    end
    push_delta(slow_track);
    if (slow_track || r < 40) begin
      gen_status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
      add_chunk_byte(gen_status);
      push_channel_data(gen_status);
    end else if (r < 58) begin
      push_channel_data(gen_status);
    end else if (r < 76) begin
      add_chunk_byte(STATUS_META);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        code = META_TEMPO;
        len = 3;
      end else if (r < 55) begin
        code = META_TIMESIG;
        len = 4;
      end else if (r < 70) begin
        code = META_END;
        len = 0;
      end else begin
        code = ($urandom_range(0, 1) != 0) ? META_TEXT : 8'($urandom_range(0, 255));
        len = $urandom_range(0, 6);
      end
      add_chunk_byte(code);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        push_vlq(28'(len));
      end else if (r < 93) begin
        len = $urandom_range(0, 6);
        push_vlq(28'(len));
      end else if (r < 98) begin
        len = $urandom_range(128, 133);
        push_vlq(28'(len));
      end else begin
        repeat (4) add_chunk_byte(8'($urandom_range(128, 255)));
        discarding = 1'b1;
        gen_status = '0;
        return;
      end
      push_payload(len);
      gen_status = '0;
    end else if (r < 88) begin
      add_chunk_byte(($urandom_range(0, 1) != 0) ? STATUS_SYSEX : STATUS_ESCAPE);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 5);
      push_vlq(28'(len));
      push_payload(len);
      gen_status = '0;
    end else if (r < 94) begin
      do code = 8'($urandom_range(8'hF1, 8'hFE)); while (code == STATUS_ESCAPE);
      add_chunk_byte(code);
    end else begin
      // stray byte where a status belongs
      add_chunk_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_random_chunk();
    int unsigned n_events;
    int unsigned cut;
    bit          slow_track;
    bit          discarding;
    logic [7:0]  gen_status;
    gen_status = '0;
    slow_track = ($urandom_range(0, 24) == 0);
    n_events = slow_track ? $urandom_range(17, 20)
             : ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int i = 0; i < n_events; i++) begin
      push_event(gen_status, slow_track, discarding);
      if (discarding) begin
        push_payload($urandom_range(0, 3));
        break;
      end
    end
    // chunk ends in the middle of an event now and then
    if ($urandom_range(0, 9) == 0 && chunk_bytes.size() > 1) begin
      cut = $urandom_range(1, 3);
      while (cut > 0 && chunk_bytes.size() > 1) begin
        void'(chunk_bytes.pop_back());
        cut--;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Note on with top-bit data, running status, program change after maximum delta
  task automatic test_channel_messages();
    chunk_bytes = '{8'h00, ST_NOTE_ON, 8'hBC, 8'hFF,
                    8'h00, 8'h3C, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'h7F, ST_PROGRAM, 8'h81,
                    8'h00, 8'h22};
    send_chunk();
  endtask

  // Data with no status, undefined status, then a note cut by the chunk end
  task automatic test_malformed_streams();
    chunk_bytes = '{8'h00, 8'h40, 8'h00, ST_UNDEFINED, 8'h00, ST_NOTE_ON, 8'h3C};
    send_chunk();
    // delta with four continuation bytes, rest of chunk ignored
    chunk_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12};
    send_chunk();
  endtask

  // Tempo with a single payload byte, ending the chunk
  task automatic test_short_tempo();
    chunk_bytes = '{8'h00, STATUS_META, META_TEMPO, 8'h01, 8'hAB};
    send_chunk();
  endtask

  task automatic test_random_chunks();
    int unsigned target;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      steady_mode = ($urandom_range(0, 4) == 0);
      build_random_chunk();
      send_chunk();
    end
    steady_mode = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    last_byte_i  = 1'b0;
    steady_mode  = 1'b0;
    kinds_seen   = '0;
    bytes_sent   = 0;
    chunks_sent  = 0;
    events_checked = 0;
    fail_count   = 0;
    clear_track_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_channel_messages();
    test_malformed_streams();
    test_short_tempo();
    test_random_chunks();

    in_valid_i = 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d chunk bytes in %0d chunks, %0d event words checked, %0d of 13 kinds seen",
             bytes_sent, chunks_sent, events_checked, $countones(kinds_seen));
    if (fail_count == 0) begin
      $display("[midi_track_event_parser] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[midi_track_event_parser] ERROR");
    end
    $finish;
  end

endmodule
